// ===== hdl/dbp_pkg.sv =====
// ----------------------------------------------------------------------------
// dbp_pkg
// Shared types and constants of the delta bit-packed stream decoder.
// ----------------------------------------------------------------------------
package dbp_pkg;

    // Depth of the byte queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Header limits.
    localparam int MAX_MINI_BLOCKS  = 16;
    localparam int MAX_BLOCK_VALUES = 64;
    localparam int MAX_RESULTS      = 64;
    localparam int MAX_BIT_WIDTH    = 32;

    // Error codes carried with a result.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_WIDTH  = 2'd2;
    localparam logic [1:0] ERR_EARLY  = 2'd3;

    // Element width selector codes.
    localparam logic [1:0] WSEL_8  = 2'd0;
    localparam logic [1:0] WSEL_16 = 2'd1;
    localparam logic [1:0] WSEL_32 = 2'd2;

    // One queued stream byte.
    typedef struct packed {
        logic       eos;
        logic [7:0] data;
    } byte_item_t;

    // One result beat.
    typedef struct packed {
        logic [63:0] value;
        logic        last;
        logic        complete;
        logic [1:0]  err;
    } result_t;

    // Mask for the configured element width.
    function automatic logic [63:0] width_mask(input logic [1:0] sel);
        logic [63:0] m;
        case (sel)
            WSEL_8:  m = 64'h0000_0000_0000_00FF;
            WSEL_16: m = 64'h0000_0000_0000_FFFF;
            WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/dbp_front.sv =====
// ----------------------------------------------------------------------------
// dbp_front
// Accepts stream beats, tags each byte with its end-of-stream mark and holds
// them in a short queue for the decode engine.
// ----------------------------------------------------------------------------
module dbp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_data,
    input  logic                in_eos,
    output logic                q_valid,
    output dbp_pkg::byte_item_t q_item,
    input  logic                q_pop
);

    localparam int PW = $clog2(dbp_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(dbp_pkg::QUEUE_DEPTH + 1);

    dbp_pkg::byte_item_t mem_reg [dbp_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready = (count_reg != CW'(dbp_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{eos: in_eos, data: in_data};
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PW'((32'(wr_ptr_reg) + 1) % dbp_pkg::QUEUE_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= PW'((32'(rd_ptr_reg) + 1) % dbp_pkg::QUEUE_DEPTH);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(dbp_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(dbp_pkg::QUEUE_DEPTH)) && !pop |=> count_reg == $past(count_reg))
        else $error("queue grew while full");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointer gap");

endmodule

// ===== hdl/dbp_core.sv =====
// ----------------------------------------------------------------------------
// dbp_core
// Decode engine: parses header and block fields, unpacks deltas one value per
// cycle unless output stalls, staging results so a byte's final one has last.
// ----------------------------------------------------------------------------
module dbp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          width_sel,
    input  logic                q_valid,
    input  dbp_pkg::byte_item_t q_item,
    output logic                q_pop,
    output logic                out_valid,
    output dbp_pkg::result_t    out_item,
    input  logic                out_ready
);

    typedef enum logic [3:0] {
        PH_BLOCK       = 4'd0,
        PH_MINI        = 4'd1,
        PH_TOTAL       = 4'd2,
        PH_FIRST       = 4'd3,
        PH_MIN_DELTA   = 4'd4,
        PH_WIDTHS      = 4'd5,
        PH_PAYLOAD_LEN = 4'd6,
        PH_PAYLOAD     = 4'd7,
        PH_DONE        = 4'd8,
        PH_ERROR       = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DRAIN,
        S_END,
        S_EOS,
        S_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [31:0]      acc_reg, acc_next;
    logic [5:0]       shift_reg, shift_next;
    logic [31:0]      block_reg, block_next;
    logic [31:0]      mini_reg, mini_next;
    logic [4:0]       mcount_reg, mcount_next;
    logic [31:0]      total_reg, total_next;
    logic [31:0]      decoded_reg, decoded_next;
    logic [63:0]      running_reg, running_next;
    logic [31:0]      min_reg, min_next;
    logic [31:0]      payload_reg, payload_next;
    logic [63:0]      buf_reg, buf_next;
    logic [6:0]       bc_reg, bc_next;
    logic [4:0]       mi_reg, mi_next;
    logic [6:0]       vim_reg, vim_next;
    logic [6:0]       vib_reg, vib_next;
    logic [10:0]      start_reg, start_next;
    logic [6:0]       rem_reg, rem_next;
    logic [4:0]       q_reg, q_next;
    logic             eos_reg, eos_next;
    logic             ctx_reg, ctx_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             pend_valid_reg, pend_valid_next;
    dbp_pkg::result_t pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    dbp_pkg::result_t out_reg, out_next;
    logic [5:0]       wtab [dbp_pkg::MAX_MINI_BLOCKS];

    logic             tbl_we;
    logic [3:0]       tbl_idx;
    logic [5:0]       tbl_d;
    logic             emit_req;
    dbp_pkg::result_t emit_res;
    logic             out_free, can_emit;
    logic [7:0]       b;
    logic [31:0]      vacc;
    logic             vdone;
    logic             finished;
    logic [5:0]       w;
    logic [31:0]      wmask, adj, left;
    logic [63:0]      mask, sum;
    logic [6:0]       diff, cntv;
    logic             incomplete;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign can_emit  = !pend_valid_reg || out_free;
    assign mask      = dbp_pkg::width_mask(width_sel);

    // Varint byte merge.
    assign b     = q_item.data;
    assign vacc  = acc_reg | ((shift_reg < 6'd32) ? (32'(b[6:0]) << shift_reg[4:0]) : 32'd0);
    assign vdone = !b[7];

    // Unpack step terms.
    assign finished = (mi_reg >= mcount_reg) || (start_reg >= {4'b0, vib_reg});
    assign w        = wtab[mi_reg[3:0]];
    assign wmask    = (w >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w[4:0]) - 32'd1);
    assign adj      = buf_reg[31:0] & wmask;
    assign sum      = (running_reg + {32'b0, adj} + {32'b0, min_reg}) & mask;
    assign diff     = vib_reg - start_reg[6:0];
    assign cntv     = (diff < mini_reg[6:0]) ? diff : mini_reg[6:0];
    assign left     = total_reg - decoded_reg;
    assign incomplete = (phase_reg != PH_DONE) && (phase_reg != PH_ERROR) &&
                        ((phase_reg < PH_MIN_DELTA) || (decoded_reg < total_reg));

    // Next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        shift_next      = shift_reg;
        block_next      = block_reg;
        mini_next       = mini_reg;
        mcount_next     = mcount_reg;
        total_next      = total_reg;
        decoded_next    = decoded_reg;
        running_next    = running_reg;
        min_next        = min_reg;
        payload_next    = payload_reg;
        buf_next        = buf_reg;
        bc_next         = bc_reg;
        mi_next         = mi_reg;
        vim_next        = vim_reg;
        vib_next        = vib_reg;
        start_next      = start_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        eos_next        = eos_reg;
        ctx_next        = ctx_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        tbl_we          = 1'b0;
        tbl_idx         = mi_reg[3:0];
        tbl_d           = b[5:0];
        emit_req        = 1'b0;
        emit_res        = '0;
        q_pop           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    eos_next   = q_item.eos;
                    ctx_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = S_END;
                    // Varint fields share the accumulator.
                    if (phase_reg inside {PH_BLOCK, PH_MINI, PH_TOTAL, PH_FIRST,
                                          PH_MIN_DELTA, PH_PAYLOAD_LEN})
                    begin
                        if (vdone)
                        begin
                            acc_next   = '0;
                            shift_next = '0;
                        end
                        else
                        begin
                            acc_next   = vacc;
                            shift_next = (shift_reg >= 6'd28) ? 6'd35 : shift_reg + 6'd7;
                        end
                    end
                    case (phase_reg)
                        PH_BLOCK:
                        begin
                            if (vdone)
                            begin
                                block_next = vacc;
                                phase_next = PH_MINI;
                            end
                        end
                        PH_MINI:
                        begin
                            if (vdone)
                            begin
                                mini_next  = vacc;
                                phase_next = PH_TOTAL;
                            end
                        end
                        PH_TOTAL:
                        begin
                            if (vdone)
                            begin
                                total_next = vacc;
                                phase_next = PH_FIRST;
                            end
                        end
                        PH_FIRST:
                        begin
                            if (vdone)
                            begin
                                running_next = {32'b0, vacc};
                                if (mini_reg == '0 || block_reg == '0 ||
                                    block_reg > 32'(dbp_pkg::MAX_BLOCK_VALUES))
                                begin
                                    emit_req   = 1'b1;
                                    emit_res   = '{value: '0, last: 1'b0, complete: 1'b0,
                                                   err: dbp_pkg::ERR_HEADER};
                                    phase_next = PH_ERROR;
                                end
                                else
                                begin
                                    rem_next   = block_reg[6:0];
                                    q_next     = '0;
                                    state_next = S_DIV;
                                end
                            end
                        end
                        PH_MIN_DELTA:
                        begin
                            if (vdone)
                            begin
                                min_next   = vacc;
                                mi_next    = '0;
                                phase_next = PH_WIDTHS;
                            end
                        end
                        PH_WIDTHS:
                        begin
                            if (b > 8'(dbp_pkg::MAX_BIT_WIDTH))
                            begin
                                emit_req   = 1'b1;
                                emit_res   = '{value: '0, last: 1'b0, complete: 1'b0,
                                               err: dbp_pkg::ERR_WIDTH};
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                tbl_we  = 1'b1;
                                mi_next = mi_reg + 5'd1;
                                if (mi_reg + 5'd1 >= mcount_reg)
                                begin
                                    phase_next = PH_PAYLOAD_LEN;
                                end
                            end
                        end
                        PH_PAYLOAD_LEN:
                        begin
                            if (vdone)
                            begin
                                payload_next = vacc;
                                vib_next     = (block_reg < left) ? block_reg[6:0] : left[6:0];
                                mi_next      = '0;
                                vim_next     = '0;
                                start_next   = '0;
                                buf_next     = '0;
                                bc_next      = '0;
                                phase_next   = PH_PAYLOAD;
                                ctx_next     = 1'b1;
                                state_next   = S_DRAIN;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            payload_next = payload_reg - 32'd1;
                            if (!finished && bc_reg <= 7'd56)
                            begin
                                buf_next = buf_reg | ({56'b0, b} << bc_reg[5:0]);
                                bc_next  = bc_reg + 7'd8;
                            end
                            ctx_next   = 1'b1;
                            state_next = S_DRAIN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Block over mini size, one subtraction per cycle.
            S_DIV:
            begin
                if ({25'b0, rem_reg} >= mini_reg)
                begin
                    if (q_reg == 5'(dbp_pkg::MAX_MINI_BLOCKS))
                    begin
                        if (can_emit)
                        begin
                            emit_req   = 1'b1;
                            emit_res   = '{value: '0, last: 1'b0, complete: 1'b0,
                                           err: dbp_pkg::ERR_HEADER};
                            phase_next = PH_ERROR;
                            state_next = S_END;
                        end
                    end
                    else
                    begin
                        rem_next = rem_reg - mini_reg[6:0];
                        q_next   = q_reg + 5'd1;
                    end
                end
                else if (can_emit)
                begin
                    emit_req   = 1'b1;
                    state_next = S_END;
                    if (q_reg == '0)
                    begin
                        emit_res   = '{value: '0, last: 1'b0, complete: 1'b0,
                                       err: dbp_pkg::ERR_HEADER};
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        mcount_next  = q_reg;
                        running_next = running_reg & mask;
                        decoded_next = 32'd1;
                        emit_res     = '{value: running_reg & mask, last: 1'b0,
                                         complete: (total_reg <= 32'd1),
                                         err: dbp_pkg::ERR_NONE};
                        phase_next   = (total_reg <= 32'd1) ? PH_DONE : PH_MIN_DELTA;
                    end
                end
            end

            // One unpacked value per cycle while a result can be emitted.
            S_DRAIN:
            begin
                if (finished ||
                    (w != '0 && {1'b0, bc_reg} < {2'b0, w} && payload_reg != '0))
                begin
                    state_next = S_END;
                end
                else if (can_emit)
                begin
                    if (w != '0)
                    begin
                        if ({1'b0, bc_reg} >= {2'b0, w})
                        begin
                            buf_next = buf_reg >> w;
                            bc_next  = bc_reg - {1'b0, w};
                        end
                        else
                        begin
                            buf_next = '0;
                            bc_next  = '0;
                        end
                    end
                    running_next = (w != '0) ? sum : ((running_reg + {32'b0, min_reg}) & mask);
                    decoded_next = decoded_reg + 32'd1;
                    emit_req     = 1'b1;
                    emit_res     = '{value: running_next, last: 1'b0,
                                     complete: (decoded_reg + 32'd1 == total_reg),
                                     err: dbp_pkg::ERR_NONE};
                    if ({1'b0, vim_reg} + 8'd1 >= {1'b0, cntv})
                    begin
                        mi_next    = mi_reg + 5'd1;
                        vim_next   = '0;
                        start_next = start_reg + {4'b0, mini_reg[6:0]};
                    end
                    else
                    begin
                        vim_next = vim_reg + 7'd1;
                    end
                end
            end

            // Close the block once its payload is used up.
            S_END:
            begin
                if (ctx_reg && payload_reg == '0)
                begin
                    buf_next   = '0;
                    bc_next    = '0;
                    phase_next = (decoded_reg >= total_reg) ? PH_DONE : PH_MIN_DELTA;
                end
                state_next = S_EOS;
            end

            // On an end-of-stream byte, flag a short stream and restart; else go to flush.
            S_EOS:
            begin
                if (!eos_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (!incomplete || cnt_reg == 7'(dbp_pkg::MAX_RESULTS) || can_emit)
                begin
                    if (incomplete)
                    begin
                        if (cnt_reg == 7'(dbp_pkg::MAX_RESULTS))
                        begin
                            pend_next = '{value: '0, last: 1'b0, complete: 1'b0,
                                          err: dbp_pkg::ERR_EARLY};
                        end
                        else
                        begin
                            emit_req = 1'b1;
                            emit_res = '{value: '0, last: 1'b0, complete: 1'b0,
                                         err: dbp_pkg::ERR_EARLY};
                        end
                    end
                    phase_next   = PH_BLOCK;
                    acc_next     = '0;
                    shift_next   = '0;
                    block_next   = '0;
                    mini_next    = '0;
                    mcount_next  = '0;
                    total_next   = '0;
                    decoded_next = '0;
                    running_next = '0;
                    min_next     = '0;
                    payload_next = '0;
                    buf_next     = '0;
                    bc_next      = '0;
                    mi_next      = '0;
                    vim_next     = '0;
                    vib_next     = '0;
                    start_next   = '0;
                    state_next   = S_FLUSH;
                end
            end

            // Hand over the held result marked as the last of this byte.
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A new result pushes the held one to the output register.
        if (emit_req)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_next.last  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
            cnt_next        = cnt_reg + 7'd1;
        end
    end

    // Bit width table.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            wtab[tbl_idx] <= tbl_d;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_BLOCK;
            acc_reg        <= '0;
            shift_reg      <= '0;
            block_reg      <= '0;
            mini_reg       <= '0;
            mcount_reg     <= '0;
            total_reg      <= '0;
            decoded_reg    <= '0;
            running_reg    <= '0;
            min_reg        <= '0;
            payload_reg    <= '0;
            buf_reg        <= '0;
            bc_reg         <= '0;
            mi_reg         <= '0;
            vim_reg        <= '0;
            vib_reg        <= '0;
            start_reg      <= '0;
            rem_reg        <= '0;
            q_reg          <= '0;
            eos_reg        <= 1'b0;
            ctx_reg        <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            shift_reg      <= shift_next;
            block_reg      <= block_next;
            mini_reg       <= mini_next;
            mcount_reg     <= mcount_next;
            total_reg      <= total_next;
            decoded_reg    <= decoded_next;
            running_reg    <= running_next;
            min_reg        <= min_next;
            payload_reg    <= payload_next;
            buf_reg        <= buf_next;
            bc_reg         <= bc_next;
            mi_reg         <= mi_next;
            vim_reg        <= vim_next;
            vib_reg        <= vib_next;
            start_reg      <= start_next;
            rem_reg        <= rem_next;
            q_reg          <= q_next;
            eos_reg        <= eos_next;
            ctx_reg        <= ctx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result left over at byte start");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 7'(dbp_pkg::MAX_RESULTS))
        else $error("too many results for one byte");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> q_reg <= 5'(dbp_pkg::MAX_MINI_BLOCKS))
        else $error("mini block quotient overran");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("byte taken while busy");

endmodule

// ===== hdl/delta_bitpack_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// delta_bitpack_stream_decoder
// Decodes a delta bit-packed column from a byte stream into elements.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one stream byte per beat in s_tdata, with s_tlast on the final
//   byte of the encoded stream. m_* returns decoded elements in m_tdata; tlast
//   marks the final result caused by one input byte, tuser carries the
//   completion flag and the error code. cfg_wr_en/cfg_wr_data set the element
//   width; write it only while the decoder is idle.
//   Bytes enter a four-entry queue, so the source keeps moving while the
//   decode engine works. The engine takes each byte through its idle, end,
//   end-of-stream and flush states; a byte that ends the header first runs
//   the mini block quotient pass, and a byte that starts or feeds an unpack
//   pass emits its values in turn, so bytes holding many narrow deltas take
//   longer. The first result of a byte is staged and reaches the output
//   register when the next result or the flush passes it on.
//   Reset empties the queue, clears all results and sets the width to 32
//   bits. A stalled receiver holds the output register and one staged result;
//   the engine then waits and the queue fills before s_tready drops.
//   After a byte marked tlast the decoder restarts for a new stream.
// ----------------------------------------------------------------------------
module delta_bitpack_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] stream_byte
    input  logic        s_tlast,    // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] value
    output logic        m_tlast,    // last_in_run
    output logic [2:0]  m_tuser,    // [0] stream_complete, [2:1] error_code
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data // value_width_sel
);

    logic [1:0]          wsel_reg;
    logic                q_valid, q_pop;
    dbp_pkg::byte_item_t q_item;
    dbp_pkg::result_t    res;

    // Element width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsel_reg <= dbp_pkg::WSEL_32;
        end
        else if (cfg_wr_en)
        begin
            wsel_reg <= cfg_wr_data;
        end
    end

    dbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_eos   (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    dbp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .width_sel (wsel_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_item  (res),
        .out_ready (m_tready)
    );

    // Output beat fields.
    assign m_tdata = res.value;
    assign m_tlast = res.last;
    assign m_tuser = {res.err, res.complete};

endmodule

// ===== test/delta_bitpack_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_bitpack_stream_decoder_tb
// Drives encoded delta bit-packed streams into the decoder, predicts every
// element, flag and error code in a behavioral decoder, and checks each
// result beat in order against the predicted queue.
// ----------------------------------------------------------------------------
module delta_bitpack_stream_decoder_tb;

    localparam int PH_BLOCK = 0, PH_MINI = 1, PH_TOTAL = 2, PH_FIRST = 3;
    localparam int PH_MIN_DELTA = 4, PH_WIDTHS = 5, PH_PAYLOAD_LEN = 6;
    localparam int PH_PAYLOAD = 7, PH_DONE = 8, PH_ERROR = 9;

    typedef struct {
        logic [63:0] value;
        logic        last;
        logic        complete;
        logic [1:0]  err;
    } elem_t;

    // Behavioral decoder plus the queue of predicted result beats.
    class dbp_scoreboard;
        elem_t       pending[$];
        elem_t       step_out[$];
        int          mismatches;
        logic [1:0]  wsel;
        int          phase;
        logic [31:0] acc;
        int          shift;
        logic [31:0] blk_vals, mini_vals, total, decoded, blk_min, pay_left;
        int          mini_cnt, mini_idx, val_in_mini, vals_in_blk, nbits;
        logic [63:0] running, bitbuf;
        logic [7:0]  widths[16];

        function new();
            wsel = dbp_pkg::WSEL_32;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_BLOCK; acc = 0; shift = 0; blk_vals = 0; mini_vals = 0;
            mini_cnt = 0; total = 0; decoded = 0; running = 0; blk_min = 0;
            pay_left = 0; bitbuf = 0; nbits = 0; mini_idx = 0; val_in_mini = 0;
            vals_in_blk = 0;
            foreach (widths[i]) widths[i] = 0;
        endfunction

        function void emit(logic [63:0] v, logic c, logic [1:0] e);
            elem_t r;
            if (step_out.size() >= dbp_pkg::MAX_RESULTS) return;
            r.value = v; r.last = 0; r.complete = c; r.err = e;
            step_out.push_back(r);
        endfunction

        // Returns 1 and the value when the varint ends on this byte.
        function bit varint(logic [7:0] b, output logic [31:0] v);
            if (shift < 32) acc |= 32'(b[6:0]) << shift;
            if (b[7]) begin
                shift = (shift + 7 > 35) ? 35 : shift + 7;
                return 0;
            end
            v = acc; acc = 0; shift = 0;
            return 1;
        endfunction

        function bit blk_done();
            if (mini_idx >= mini_cnt) return 1;
            return 32'(mini_idx) * mini_vals >= 32'(vals_in_blk);
        endfunction

        // Unpack every value whose bits are present.
        function void unpack();
            int w;
            logic [31:0] delta, start, cnt;
            while (!blk_done()) begin
                w = widths[mini_idx & 15];
                delta = 0;
                if (w != 0 && nbits < w && pay_left != 0) break;
                if (w != 0) begin
                    delta = 32'(bitbuf & ((64'd1 << w) - 1));
                    if (nbits >= w) begin
                        bitbuf >>= w; nbits -= w;
                    end
                    else begin
                        bitbuf = 0; nbits = 0;
                    end
                end
                running = (running + 64'(delta) + 64'(blk_min)) & dbp_pkg::width_mask(wsel);
                decoded++;
                emit(running, decoded == total, dbp_pkg::ERR_NONE);
                start = 32'(mini_idx) * mini_vals;
                cnt = 32'(vals_in_blk) - start;
                if (cnt > mini_vals) cnt = mini_vals;
                val_in_mini++;
                if (val_in_mini >= cnt) begin
                    mini_idx++; val_in_mini = 0;
                end
            end
        endfunction

        function void end_block();
            bitbuf = 0; nbits = 0;
            phase = (decoded >= total) ? PH_DONE : PH_MIN_DELTA;
        endfunction

        // Notes one accepted stream byte and queues its results.
        function void note_byte(logic [7:0] b, logic eos);
            logic [31:0] v, q, left;
            bit early;
            step_out.delete();
            case (phase)
                PH_BLOCK: if (varint(b, v)) begin blk_vals = v; phase = PH_MINI; end
                PH_MINI:  if (varint(b, v)) begin mini_vals = v; phase = PH_TOTAL; end
                PH_TOTAL: if (varint(b, v)) begin total = v; phase = PH_FIRST; end
                PH_FIRST: if (varint(b, v)) begin
                    q = (mini_vals != 0) ? blk_vals / mini_vals : 0;
                    if (mini_vals == 0 || blk_vals == 0 || blk_vals > dbp_pkg::MAX_BLOCK_VALUES
                        || q == 0 || q > dbp_pkg::MAX_MINI_BLOCKS) begin
                        emit(0, 0, dbp_pkg::ERR_HEADER); phase = PH_ERROR;
                    end
                    else begin
                        mini_cnt = q;
                        running = 64'(v) & dbp_pkg::width_mask(wsel);
                        decoded = 1;
                        emit(running, total <= 1, dbp_pkg::ERR_NONE);
                        phase = (total <= 1) ? PH_DONE : PH_MIN_DELTA;
                    end
                end
                PH_MIN_DELTA: if (varint(b, v)) begin
                    blk_min = v; mini_idx = 0; phase = PH_WIDTHS;
                end
                PH_WIDTHS: begin
                    if (b > dbp_pkg::MAX_BIT_WIDTH) begin
                        emit(0, 0, dbp_pkg::ERR_WIDTH); phase = PH_ERROR;
                    end
                    else begin
                        widths[mini_idx & 15] = b;
                        mini_idx++;
                        if (mini_idx >= mini_cnt) phase = PH_PAYLOAD_LEN;
                    end
                end
                PH_PAYLOAD_LEN: if (varint(b, v)) begin
                    left = total - decoded;
                    pay_left = v;
                    vals_in_blk = 8'(blk_vals < left ? blk_vals : left);
                    mini_idx = 0; val_in_mini = 0; bitbuf = 0; nbits = 0;
                    unpack();
                    if (pay_left == 0) end_block();
                    else phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    pay_left--;
                    if (!blk_done() && nbits <= 56) begin
                        bitbuf |= 64'(b) << nbits; nbits += 8;
                    end
                    unpack();
                    if (pay_left == 0) end_block();
                end
                default: ;
            endcase
            if (eos) begin
                early = phase != PH_DONE && phase != PH_ERROR &&
                        (phase < PH_MIN_DELTA || decoded < total);
                if (early) begin
                    if (step_out.size() >= dbp_pkg::MAX_RESULTS) void'(step_out.pop_back());
                    emit(0, 0, dbp_pkg::ERR_EARLY);
                end
                restart();
            end
            if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
            foreach (step_out[i]) pending.push_back(step_out[i]);
        endfunction

        // Compares one result beat with the oldest prediction.
        function void check_beat(logic [63:0] v, logic l, logic c, logic [1:0] e);
            elem_t x;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat value=%h last=%b cpl=%b err=%0d",
                             v, l, c, e);
                return;
            end
            x = pending.pop_front();
            if (x.value !== v || x.last !== l || x.complete !== c || x.err !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp value=%h last=%b cpl=%b err=%0d, ",
                              "got value=%h last=%b cpl=%b err=%0d"},
                             x.value, x.last, x.complete, x.err, v, l, c, e);
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        s_tvalid, s_tready, s_tlast;
    logic [7:0]  s_tdata;
    logic        m_tvalid, m_tready, m_tlast;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;

    dbp_scoreboard sb;
    byte unsigned  stream_q[$];
    bit            eos_q[$];
    bit            tx_gaps, rx_gaps, rx_hold;

    delta_bitpack_stream_decoder dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAIL delta_bitpack_stream_decoder");
        $finish;
    end

    // Note accepted bytes and check accepted result beats.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tlast, m_tuser[0], m_tuser[2:1]);
    end

    // Receiver: random stall bursts, or a long hold when asked.
    initial
    begin
        int n;
        m_tready = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (rx_hold) begin
                m_tready <= 0;
                repeat (300) @(posedge clk);
                rx_hold = 0;
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 13);
                m_tready <= 0;
                repeat (n) @(posedge clk);
            end
            else begin
                m_tready <= 1;
                @(posedge clk);
            end
        end
    end

    task automatic put_varint(logic [31:0] v);
        do begin
            stream_q.push_back({v > 127, v[6:0]});
            eos_q.push_back(0);
            v >>= 7;
        end while (v != 0);
    endtask

    task automatic put_byte(byte unsigned b);
        stream_q.push_back(b);
        eos_q.push_back(0);
    endtask

    task automatic mark_end();
        eos_q[eos_q.size() - 1] = 1;
    endtask

    // Builds one well-formed stream with random content, sometimes broken.
    task automatic build_stream(bit allow_bad);
        int bs, ms, mc, total, left, w, nb, k;
        bs = 8 * $urandom_range(1, 8);
        mc = 1 << $urandom_range(0, 3);
        while (bs / mc == 0) mc = mc / 2;
        ms = bs / mc;
        total = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(2, 70);
        put_varint(bs); put_varint(ms); put_varint(total); put_varint($urandom);
        left = total - 1;
        while (left > 0) begin
            put_varint($urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom);
            w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32) : $urandom_range(0, 6);
            for (int i = 0; i < mc; i++)
                put_byte(allow_bad && $urandom_range(0, 40) == 0 ? $urandom_range(33, 255) : w);
            nb = (w * bs + 7) / 8;
            k = $urandom_range(0, 4);
            if (k == 0) nb = $urandom_range(0, nb);
            else if (k == 1) nb = nb + $urandom_range(1, 3);
            put_varint(nb);
            repeat (nb) put_byte($urandom);
            left -= bs;
        end
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) put_byte($urandom);
        if (allow_bad && $urandom_range(0, 6) == 0 && stream_q.size() > 2)
            repeat ($urandom_range(1, 2)) begin
                void'(stream_q.pop_back()); void'(eos_q.pop_back());
            end
        mark_end();
    endtask

    // Sends all queued bytes with optional random gaps.
    task automatic send_queued();
        byte unsigned b;
        bit e;
        while (stream_q.size() > 0) begin
            if (tx_gaps && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            b = stream_q.pop_front();
            e = eos_q.pop_front();
            s_tvalid <= 1; s_tdata <= b; s_tlast <= e;
            @(posedge clk iff s_tready);
        end
        s_tvalid <= 0;
    endtask

    // Waits until the last accepted byte is noted, then for its results.
    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_width(logic [1:0] sel);
        cfg_wr_en <= 1; cfg_wr_data <= sel;
        @(posedge clk);
        cfg_wr_en <= 0;
        sb.wsel = sel;
    endtask

    initial
    begin
        sb = new();
        rst_n = 0; s_tvalid = 0; s_tdata = 0; s_tlast = 0;
        cfg_wr_en = 0; cfg_wr_data = 0;
        tx_gaps = 0; rx_gaps = 0; rx_hold = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: wide header varint, width 32, extra payload, at reset width.
        put_varint(8); put_varint(8); put_varint(4); put_byte(8'hFF);
        put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF);
        put_byte(8'h7F);
        put_varint(32'h7FFF_FFFF); put_byte(32); put_varint(40);
        repeat (40) put_byte($urandom);
        mark_end();
        send_queued();
        wait_drained();
        write_width(dbp_pkg::WSEL_8);
        // Bad header, then width over 32, then early end inside the header.
        put_varint(0); put_varint(1); put_varint(3); put_varint(5); mark_end();
        put_varint(8); put_varint(2); put_varint(9); put_varint(1);
        put_varint(1); put_byte(33); mark_end();
        put_varint(4); put_byte(8'h80); mark_end();
        // Zero-width deltas with empty payload, then a short payload.
        put_varint(64); put_varint(4); put_varint(200); put_varint(255);
        put_varint(3); repeat (16) put_byte(0); put_varint(0);
        put_varint(1); repeat (16) put_byte(1); put_varint(2);
        put_byte(8'hAA); put_byte(8'h55); mark_end();
        send_queued();
        wait_drained();

        // Random streams under several widths, with both sides idling.
        tx_gaps = 1; rx_gaps = 1;
        for (int p = 0; p < 4; p++) begin
            write_width(p[1:0]);
            build_stream(1);
            if (p == 1) rx_hold = 1;
            send_queued();
            wait_drained();
        end
        write_width(dbp_pkg::WSEL_16);
        // Final part with no idling.
        tx_gaps = 0; rx_gaps = 0;
        for (int s = 0; s < 3; s++) build_stream(0);
        send_queued();

        wait_drained();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS delta_bitpack_stream_decoder");
        else
            $display("FAIL delta_bitpack_stream_decoder");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/dbp_pkg.sv
hdl/dbp_front.sv
hdl/dbp_core.sv
hdl/delta_bitpack_stream_decoder.sv
test/delta_bitpack_stream_decoder_tb.sv
